// ===== design/lane_arrow_sorted_table_assert.svh =====
// assertion macros shared by the lane table rtl
`ifndef LANE_ARROW_SORTED_TABLE_ASSERT_SVH
`define LANE_ARROW_SORTED_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// plain property, checked at every rising edge outside reset
`define LST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define LST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define LST_ASSERT(lbl, clk, rstn, prop, msg)
`define LST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/lst_pkg.sv =====
`timescale 1ns / 1ps

package lst_pkg;

  localparam int DEF_MAX_LANES  = 8;
  localparam int DEF_MAX_ARROWS = 4;
  localparam int RESULT_CAP     = 32;

  localparam int CODE_W   = 8;
  localparam int ANGLE_W  = 10;
  localparam int STATUS_W = 3;
  localparam int ACTION_W = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_MERGED     = 3'd1,
    ST_LANE_FULL  = 3'd2,
    ST_ARROW_FULL = 3'd3,
    ST_CLEARED    = 3'd4,
    ST_ENTRY      = 3'd5,
    ST_EMPTY      = 3'd6
  } status_t;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP  = 2'd2;

endpackage

// ===== design/lst_hl.sv =====
`timescale 1ns / 1ps

// highlight test: arrow code against the clockwise octant of the turn angle
module lst_hl (
  input  logic [lst_pkg::CODE_W-1:0]         arrow_code,
  input  logic signed [lst_pkg::ANGLE_W-1:0] turn_angle,
  output logic                               match
);

  localparam int FULL_TURN = 360;
  localparam int HALF_OCT  = 45;   // 22.5 degrees, doubled
  localparam int OCT_STEP  = 90;   // 45 degrees, doubled
  localparam int MAX_Q     = 11;   // 2*512+45 stays below 12*90

  logic signed [10:0] sum;
  logic signed [10:0] rem;
  logic signed [10:0] cw;
  logic [11:0]        dbl;
  logic [3:0]         q;

  assign sum = 11'sd360 + 11'(turn_angle);

  // remainder truncates toward zero, sum never reaches three turns
  always_comb begin
    if (sum < 11'sd0) begin
      rem = sum;
    end else if (sum >= 11'(2 * FULL_TURN)) begin
      rem = sum - 11'(2 * FULL_TURN);
    end else if (sum >= 11'(FULL_TURN)) begin
      rem = sum - 11'(FULL_TURN);
    end else begin
      rem = sum;
    end
  end

  assign cw  = 11'sd360 - rem;
  assign dbl = 12'({cw[9:0], 1'b0}) + 12'(HALF_OCT);

  // quotient by 90 as a row of constant compares
  always_comb begin
    q = 4'd0;
    for (int k = 1; k <= MAX_Q; k++) begin
      if (dbl >= 12'(OCT_STEP * k)) begin
        q = 4'(k);
      end
    end
  end

  assign match = (arrow_code == lst_pkg::CODE_W'(q[2:0]));

endmodule

// ===== design/lane_arrow_sorted_table.sv =====
`timescale 1ns / 1ps
// lane table kept sorted by lane number, each lane with a short arrow list
// in_*  : command items; in_tuser carries the action (clear, add, dump)
// out_* : result items; out_tuser carries the status, out_tlast ends a command
// clear  : one result, registered from S_CLR once the output register is free
// add    : a linear search over the lane memory, one lane per cycle; a match
//          appends the arrow to that lane, else for a new lane a shift of the
//          later lanes (each read then written on the single memory port pair)
//          and the insert, or a lane-full result when the table is full
// dump   : one result per cycle per stored arrow while the output is free, capped at RESULT_CAP
// a new command is taken only once the previous one has issued its last
// result, while that result may still wait in the output register
// reset clears the sequencer, the output valid and the lane count; lane and
// arrow memories are never swept, entries past the count are simply not read
// a stalled receiver holds the output register, and a state with a result to
// issue waits in place with its memory read repeated
module lane_arrow_sorted_table #(
  parameter int MAX_LANES  = lst_pkg::DEF_MAX_LANES,
  parameter int MAX_ARROWS = lst_pkg::DEF_MAX_ARROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // lane_number[7:0], car_type[15:8], lane_kind[23:16], arrow_code[31:24],
  // turn_angle[41:32], zero fill above
  input  logic [lst_pkg::IN_DATA_W-1:0]    in_tdata,
  // action[1:0]
  input  logic [lst_pkg::ACTION_W-1:0]     in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // lane_slot[2:0], out_lane_number[10:3], out_car_type[18:11],
  // out_lane_kind[26:19], highlight[27], arrow_total[30:28],
  // arrow_slot[32:31], out_arrow_code[40:33], zero fill above
  output logic [lst_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [lst_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

`include "lane_arrow_sorted_table_assert.svh"

  localparam int SW = $clog2(MAX_LANES);
  localparam int NW = $clog2(MAX_LANES + 1);
  localparam int AW = (MAX_ARROWS > 1) ? $clog2(MAX_ARROWS) : 1;
  localparam int CW = $clog2(MAX_ARROWS + 1);
  localparam int KW = $clog2(lst_pkg::RESULT_CAP);

  typedef struct packed {
    logic [7:0]    number;
    logic [7:0]    car;
    logic [7:0]    kind;
    logic          hl;
    logic [CW-1:0] count;
  } lane_t;

  typedef logic [MAX_ARROWS-1:0][lst_pkg::CODE_W-1:0] row_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] code;
    logic [1:0] aslot;
    logic [2:0] total;
    logic       hl;
    logic [7:0] kind;
    logic [7:0] car;
    logic [7:0] number;
    logic [2:0] slot;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_EMPTY,
    S_CMP,
    S_SHR,
    S_SHW,
    S_INS,
    S_DROP,
    S_DUMP
  } state_t;

  // lane memory and arrow row memory, one row per lane slot
  lane_t lane_mem [MAX_LANES];
  row_t  arrow_mem [MAX_LANES];
  lane_t lane_rd_r;
  row_t  row_rd_r;

  logic [SW-1:0] raddr;
  logic [SW-1:0] waddr;
  logic          mem_we;
  lane_t         wlane;
  row_t          wrow;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   lane_cnt_r, lane_cnt_nxt;
  logic [NW-1:0]   pos_r, pos_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   arr_r, arr_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [7:0]      key_r, car_r, kind_r, code_r;
  logic            hl_r;

  logic                          out_tvalid_r;
  out_item_t                     out_item_r;
  lst_pkg::status_t              out_status_r;
  logic                          out_tlast_r;

  logic              emit;
  out_item_t         res;
  lst_pkg::status_t  res_status;
  logic              res_last;
  logic              out_free;
  logic              in_acc;
  logic              hl_in;
  logic              dump_end;
  logic [NW-1:0]     miss_pos;
  row_t              merge_row;
  lane_t             e;

  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign e         = lane_rd_r;

  lst_hl u_hl (
    .arrow_code (in_tdata[31:24]),
    .turn_angle ($signed(in_tdata[41:32])),
    .match      (hl_in)
  );

  always_comb begin
    merge_row = row_rd_r;
    merge_row[e.count[AW-1:0]] = code_r;
  end

  assign miss_pos = (e.number < key_r) ? NW'(pos_r + 1'b1) : pos_r;
  assign dump_end = (k_r == KW'(lst_pkg::RESULT_CAP - 1)) ||
                    ((NW'(pos_r + 1'b1) == lane_cnt_r) && (CW'(arr_r + 1'b1) == e.count));

  always_comb begin
    state_nxt    = state_r;
    lane_cnt_nxt = lane_cnt_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    arr_nxt      = arr_r;
    k_nxt        = k_r;
    raddr        = pos_r[SW-1:0];
    waddr        = pos_r[SW-1:0];
    mem_we       = 1'b0;
    wlane        = e;
    wrow         = row_rd_r;
    emit         = 1'b0;
    res          = '0;
    res_status   = lst_pkg::ST_CLEARED;
    res_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (in_acc) begin
          pos_nxt = '0;
          arr_nxt = '0;
          k_nxt   = '0;
          case (in_tuser)
            lst_pkg::ACT_CLEAR: state_nxt = S_CLR;
            lst_pkg::ACT_ADD:   state_nxt = (lane_cnt_r == '0) ? S_INS : S_CMP;
            lst_pkg::ACT_DUMP:  state_nxt = (lane_cnt_r == '0) ? S_EMPTY : S_DUMP;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      S_CLR: begin
        res_status = lst_pkg::ST_CLEARED;
        if (out_free) begin
          emit         = 1'b1;
          lane_cnt_nxt = '0;
          state_nxt    = S_IDLE;
        end
      end

      S_EMPTY: begin
        res_status = lst_pkg::ST_EMPTY;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_CMP: begin
        res.slot   = 3'(pos_r);
        res.number = e.number;
        res.car    = e.car;
        res.kind   = e.kind;
        res.code   = code_r;
        if (e.number == key_r) begin
          if (e.count < CW'(MAX_ARROWS)) begin
            // append to the existing lane
            res_status = lst_pkg::ST_MERGED;
            res.hl     = hl_r;
            res.total  = 3'(CW'(e.count + 1'b1));
            res.aslot  = 2'(e.count);
            wlane       = e;
            wlane.hl    = hl_r;
            wlane.count = CW'(e.count + 1'b1);
            wrow        = merge_row;
          end else begin
            res_status = lst_pkg::ST_ARROW_FULL;
            res.hl     = e.hl;
            res.total  = 3'(e.count);
          end
          if (out_free) begin
            emit      = 1'b1;
            mem_we    = (res_status == lst_pkg::ST_MERGED);
            state_nxt = S_IDLE;
          end
        end else if ((e.number < key_r) && (NW'(pos_r + 1'b1) < lane_cnt_r)) begin
          pos_nxt = NW'(pos_r + 1'b1);
          raddr   = pos_nxt[SW-1:0];
        end else begin
          pos_nxt = miss_pos;
          idx_nxt = lane_cnt_r;
          if (lane_cnt_r == NW'(MAX_LANES)) begin
            state_nxt = S_DROP;
          end else if (miss_pos == lane_cnt_r) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_SHR;
          end
        end
      end

      S_SHR: begin
        raddr     = SW'(idx_r - 1'b1);
        state_nxt = S_SHW;
      end

      S_SHW: begin
        // move one lane up by a slot
        mem_we    = 1'b1;
        waddr     = idx_r[SW-1:0];
        idx_nxt   = NW'(idx_r - 1'b1);
        state_nxt = (NW'(idx_r - 1'b1) == pos_r) ? S_INS : S_SHR;
      end

      S_INS: begin
        res_status   = lst_pkg::ST_INSERTED;
        res.slot     = 3'(pos_r);
        res.number   = key_r;
        res.car      = car_r;
        res.kind     = kind_r;
        res.hl       = hl_r;
        res.total    = 3'd1;
        res.code     = code_r;
        wlane.number = key_r;
        wlane.car    = car_r;
        wlane.kind   = kind_r;
        wlane.hl     = hl_r;
        wlane.count  = CW'(1);
        wrow         = '0;
        wrow[0]      = code_r;
        if (out_free) begin
          emit         = 1'b1;
          mem_we       = 1'b1;
          lane_cnt_nxt = NW'(lane_cnt_r + 1'b1);
          state_nxt    = S_IDLE;
        end
      end

      S_DROP: begin
        res_status = lst_pkg::ST_LANE_FULL;
        res.number = key_r;
        res.code   = code_r;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DUMP: begin
        res_status = lst_pkg::ST_ENTRY;
        res.slot   = 3'(pos_r);
        res.number = e.number;
        res.car    = e.car;
        res.kind   = e.kind;
        res.hl     = e.hl;
        res.total  = 3'(e.count);
        res.aslot  = 2'(arr_r);
        res.code   = row_rd_r[arr_r[AW-1:0]];
        res_last   = dump_end;
        if (out_free) begin
          emit  = 1'b1;
          k_nxt = KW'(k_r + 1'b1);
          if (dump_end) begin
            state_nxt = S_IDLE;
          end else if (CW'(arr_r + 1'b1) < e.count) begin
            arr_nxt = CW'(arr_r + 1'b1);
          end else begin
            // next lane, its row arrives next cycle
            arr_nxt = '0;
            pos_nxt = NW'(pos_r + 1'b1);
            raddr   = pos_nxt[SW-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memories: registered read, single write port
  always_ff @(posedge clk) begin
    lane_rd_r <= lane_mem[raddr];
    row_rd_r  <= arrow_mem[raddr];
    if (mem_we) begin
      lane_mem[waddr]  <= wlane;
      arrow_mem[waddr] <= wrow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lane_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lane_cnt_r <= lane_cnt_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    arr_r <= arr_nxt;
    k_r   <= k_nxt;
    if (in_acc) begin
      key_r  <= in_tdata[7:0];
      car_r  <= in_tdata[15:8];
      kind_r <= in_tdata[23:16];
      code_r <= in_tdata[31:24];
      hl_r   <= hl_in;
    end
    if (emit) begin
      out_item_r   <= res;
      out_status_r <= res_status;
      out_tlast_r  <= res_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = lst_pkg::OUT_DATA_W'(out_item_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_tlast_r;

  `LST_ASSERT(a_cnt_bound, clk, rst_n, lane_cnt_r <= NW'(MAX_LANES), "lane count past table size")
  `LST_ASSERT_IMP(a_dump_slot, clk, rst_n, state_r == S_DUMP, pos_r < lane_cnt_r, "dump past last lane")
  `LST_ASSERT_IMP(a_shift_range, clk, rst_n, state_r == S_SHW, (idx_r > pos_r) && (idx_r <= lane_cnt_r), "shift index out of range")
  `LST_ASSERT_IMP(a_ins_room, clk, rst_n, state_r == S_INS, lane_cnt_r < NW'(MAX_LANES), "insert into full table")

endmodule
